// File: sv/hslrgb_pkg.sv
// ============================================================================
// hslrgb_pkg
// Shared widths and constants for the HSL to RGB converter.
// ============================================================================
package hslrgb_pkg;

    // Input field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int LVL_W = 8;

    // Input limits
    localparam logic [HUE_W-1:0] HUE_LIMIT = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

    // Channel numerator over the common denominator 600000 (max 600000)
    localparam int NUM_W = 20;

    // level = floor((17*N + 20000) / 40000) = floor(((17*N + 20000) >> 6) / 625)
    localparam int X_W   = 24;
    localparam int Q_W   = X_W - 6;
    localparam logic [X_W-1:0] SCALE_MUL  = 24'd17;
    localparam logic [X_W-1:0] SCALE_BIAS = 24'd20000;

    // Reciprocal of 625: floor(2^26 / 625), estimate low by at most one
    localparam int RCP_W   = 17;
    localparam int PROD_W  = Q_W + RCP_W;
    localparam int RCP_SH  = 26;
    localparam int EST_W   = PROD_W - RCP_SH;
    localparam int BACK_W  = 19;
    localparam logic [RCP_W-1:0]  RECIP   = 17'd107374;
    localparam logic [BACK_W-1:0] DIVISOR = 19'd625;

    localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;

endpackage

// File: sv/hslrgb_chan_scale.sv
// ============================================================================
// hslrgb_chan_scale
// Three-stage scale of one channel numerator to an 8-bit level, rounded.
// ============================================================================
module hslrgb_chan_scale (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [hslrgb_pkg::NUM_W-1:0]    i_num,
    output logic [hslrgb_pkg::LVL_W-1:0]    o_level
);

    logic [hslrgb_pkg::X_W-1:0]    w_x;
    logic [hslrgb_pkg::Q_W-1:0]    r_q_a, n_q_a;
    logic [hslrgb_pkg::PROD_W-1:0] w_prod;
    logic [hslrgb_pkg::Q_W-1:0]    r_q_b;
    logic [hslrgb_pkg::EST_W-1:0]  r_est, n_est;
    logic [hslrgb_pkg::BACK_W-1:0] w_back;
    logic [hslrgb_pkg::BACK_W-1:0] w_rem;
    logic [hslrgb_pkg::EST_W-1:0]  w_fix;
    logic [hslrgb_pkg::LVL_W-1:0]  r_level, n_level;

    // stage A: bias and drop the power-of-two part of the divisor
    always_comb begin
        w_x   = {{(hslrgb_pkg::X_W-hslrgb_pkg::NUM_W){1'b0}}, i_num} * hslrgb_pkg::SCALE_MUL
                + hslrgb_pkg::SCALE_BIAS;
        n_q_a = w_x[hslrgb_pkg::X_W-1:hslrgb_pkg::X_W-hslrgb_pkg::Q_W];
    end

    // stage B: reciprocal multiply
    always_comb begin
        w_prod = {{hslrgb_pkg::RCP_W{1'b0}}, r_q_a}
                 * {{hslrgb_pkg::Q_W{1'b0}}, hslrgb_pkg::RECIP};
        n_est  = w_prod[hslrgb_pkg::PROD_W-1:hslrgb_pkg::RCP_SH];
    end

    // stage C: one correction step, then clamp
    always_comb begin
        w_back = {{(hslrgb_pkg::BACK_W-hslrgb_pkg::EST_W){1'b0}}, r_est} * hslrgb_pkg::DIVISOR;
        w_rem  = {{(hslrgb_pkg::BACK_W-hslrgb_pkg::Q_W){1'b0}}, r_q_b} - w_back;
        w_fix  = (w_rem >= hslrgb_pkg::DIVISOR) ? r_est + 1'b1 : r_est;
        if (w_fix > {1'b0, hslrgb_pkg::LVL_MAX}) begin
            n_level = hslrgb_pkg::LVL_MAX;
        end else begin
            n_level = w_fix[hslrgb_pkg::LVL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_a   <= n_q_a;
            r_q_b   <= r_q_a;
            r_est   <= n_est;
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

// File: sv/hsl_to_rgb_converter_top.sv
// ============================================================================
// hsl_to_rgb_converter_top
// Pipelined HSL to 8-bit RGB color conversion, one pixel per clock while the output is not stalled.
// ============================================================================
// Usage:
//   Input channel: i_in_valid / o_in_ready carry hue (degrees, 0..360),
//   saturation and lightness (percent, 0..100). Output channel:
//   o_out_valid / i_out_ready carry red, green, blue levels and an
//   invalid flag. Out-of-range inputs give the flag with all levels zero.
//   Path: the accepting edge loads S1; the beat then passes S2..S6 and the
//   output register before it is on the outputs.
//   Throughput: one beat per cycle, sustained, as long as the receiver
//   takes beats; every stage of the pipeline is a single register level.
//   Stalls: the pipeline moves whenever the skid is empty; a beat
//   that leaves the pipeline while the output is held lands in a one-entry
//   skid register, and o_in_ready (a register) drops until the skid drains.
//   Nothing is dropped or repeated.
//   Reset: i_rst_n low, synchronous, clears every valid bit; data registers
//   are not reset. The block is ready the cycle after reset releases.
// Pipeline:
//   S1 range check, span |2L-1| form, hue sector and ramp factor
//   S2 chroma numerator span*S
//   S3 C, X and m numerators, sector routing, per-channel sum
//   S4..S6 per channel: bias, reciprocal divide by 40000, correct, clamp
// ============================================================================
module hsl_to_rgb_converter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hslrgb_pkg::HUE_W-1:0]      i_hue_degrees,
    input  logic [hslrgb_pkg::PCT_W-1:0]      i_saturation_pct,
    input  logic [hslrgb_pkg::PCT_W-1:0]      i_lightness_pct,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hslrgb_pkg::LVL_W-1:0]      o_red_level,
    output logic [hslrgb_pkg::LVL_W-1:0]      o_green_level,
    output logic [hslrgb_pkg::LVL_W-1:0]      o_blue_level,
    output logic                              o_input_invalid
);

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RY,     // red to yellow
        SEC_YG,     // yellow to green
        SEC_GC,     // green to cyan
        SEC_CB,     // cyan to blue
        SEC_BM,     // blue to magenta
        SEC_MR      // magenta to red, also 360
    } t_sector;

    typedef struct packed {
        logic [hslrgb_pkg::LVL_W-1:0] red;
        logic [hslrgb_pkg::LVL_W-1:0] green;
        logic [hslrgb_pkg::LVL_W-1:0] blue;
        logic                         invalid;
    } t_pix;

    // output register plus skid state
    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_pix r_out_pix, n_out_pix;
    t_pix r_skid_pix, n_skid_pix;
    logic w_push, w_pop;

    // global advance: the whole pipeline moves while the skid is empty
    logic w_en;
    assign w_en = !r_skid_valid;

    // ------------------------------------------------------------------
    // valid and invalid-flag chains
    // ------------------------------------------------------------------
    logic [5:0] r_vld;
    logic [5:0] r_inv;
    logic       w_inv;

    assign w_inv = (i_hue_degrees > hslrgb_pkg::HUE_LIMIT)
                || (i_saturation_pct > hslrgb_pkg::PCT_MAX)
                || (i_lightness_pct > hslrgb_pkg::PCT_MAX);

    // ------------------------------------------------------------------
    // S1
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::HUE_W-1:0] w_hm;
    logic [5:0]                   n_f1, r_f1, r_f2;
    t_sector                      n_sec1, r_sec1, r_sec2;
    logic [hslrgb_pkg::PCT_W:0]   w_l2;
    logic [hslrgb_pkg::PCT_W-1:0] n_span1, r_span1;
    logic [hslrgb_pkg::PCT_W-1:0] r_s1, r_l1, r_l2;

    always_comb begin
        // hue reduced to 0..120 by compare and subtract
        if (i_hue_degrees >= 9'd240) begin
            w_hm = i_hue_degrees - 9'd240;
        end else if (i_hue_degrees >= 9'd120) begin
            w_hm = i_hue_degrees - 9'd120;
        end else begin
            w_hm = i_hue_degrees;
        end
        // ramp factor 60 - |hm - 60|
        if (w_hm >= 9'd60) begin
            n_f1 = 6'(9'd120 - w_hm);
        end else begin
            n_f1 = w_hm[5:0];
        end

        if (i_hue_degrees < 9'd60) begin
            n_sec1 = SEC_RY;
        end else if (i_hue_degrees < 9'd120) begin
            n_sec1 = SEC_YG;
        end else if (i_hue_degrees < 9'd180) begin
            n_sec1 = SEC_GC;
        end else if (i_hue_degrees < 9'd240) begin
            n_sec1 = SEC_CB;
        end else if (i_hue_degrees < 9'd300) begin
            n_sec1 = SEC_BM;
        end else begin
            n_sec1 = SEC_MR;
        end

        // 100 - |2L - 100|
        w_l2 = {i_lightness_pct, 1'b0};
        if (w_l2 >= 8'd100) begin
            n_span1 = 7'(8'd200 - w_l2);
        end else begin
            n_span1 = w_l2[hslrgb_pkg::PCT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // S2: chroma numerator
    // ------------------------------------------------------------------
    logic [13:0] n_cn2, r_cn2;

    assign n_cn2 = {7'b0, r_span1} * {7'b0, r_s1};

    // ------------------------------------------------------------------
    // S3: component numerators and routing
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::NUM_W-1:0] w_cnum, w_xnum, w_mnum;
    logic [14:0]                  w_mbase;
    logic [hslrgb_pkg::NUM_W:0]   w_rsum, w_gsum, w_bsum;
    logic [hslrgb_pkg::NUM_W-1:0] w_r, w_g, w_b;
    logic [hslrgb_pkg::NUM_W-1:0] n_rn3, n_gn3, n_bn3, r_rn3, r_gn3, r_bn3;

    always_comb begin
        w_cnum  = {6'b0, r_cn2} * 20'd60;
        w_xnum  = {6'b0, r_cn2} * {14'b0, r_f2};
        w_mbase = {8'b0, r_l2} * 15'd200 - {1'b0, r_cn2};
        w_mnum  = {5'b0, w_mbase} * 20'd30;

        case (r_sec2)
            SEC_RY: begin w_r = w_cnum; w_g = w_xnum; w_b = '0;     end
            SEC_YG: begin w_r = w_xnum; w_g = w_cnum; w_b = '0;     end
            SEC_GC: begin w_r = '0;     w_g = w_cnum; w_b = w_xnum; end
            SEC_CB: begin w_r = '0;     w_g = w_xnum; w_b = w_cnum; end
            SEC_BM: begin w_r = w_xnum; w_g = '0;     w_b = w_cnum; end
            default: begin w_r = w_cnum; w_g = '0;    w_b = w_xnum; end
        endcase

        w_rsum = {1'b0, w_r} + {1'b0, w_mnum};
        w_gsum = {1'b0, w_g} + {1'b0, w_mnum};
        w_bsum = {1'b0, w_b} + {1'b0, w_mnum};

        // a zero numerator scales to level zero
        if (r_inv[1]) begin
            n_rn3 = '0;
            n_gn3 = '0;
            n_bn3 = '0;
        end else begin
            n_rn3 = w_rsum[hslrgb_pkg::NUM_W-1:0];
            n_gn3 = w_gsum[hslrgb_pkg::NUM_W-1:0];
            n_bn3 = w_bsum[hslrgb_pkg::NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1    <= n_f1;
            r_sec1  <= n_sec1;
            r_span1 <= n_span1;
            r_s1    <= i_saturation_pct;
            r_l1    <= i_lightness_pct;
            r_cn2   <= n_cn2;
            r_f2    <= r_f1;
            r_sec2  <= r_sec1;
            r_l2    <= r_l1;
            r_rn3   <= n_rn3;
            r_gn3   <= n_gn3;
            r_bn3   <= n_bn3;
            r_inv   <= {r_inv[4:0], w_inv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[4:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // S4..S6: per-channel scaling
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::LVL_W-1:0] w_red, w_green, w_blue;
    t_pix                         w_new;

    hslrgb_chan_scale u_scale_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_rn3),
        .o_level (w_red)
    );

    hslrgb_chan_scale u_scale_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_gn3),
        .o_level (w_green)
    );

    hslrgb_chan_scale u_scale_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_bn3),
        .o_level (w_blue)
    );

    assign w_new = '{red: w_red, green: w_green, blue: w_blue, invalid: r_inv[5]};

    // ------------------------------------------------------------------
    // output register plus skid
    // ------------------------------------------------------------------
    assign w_push = w_en && r_vld[5];
    assign w_pop  = r_out_valid && i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_pix    = r_out_pix;
        n_skid_pix   = r_skid_pix;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out_pix    = r_skid_pix;
                n_skid_valid = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                n_out_pix   = w_new;
                n_out_valid = 1'b1;
            end else begin
                n_skid_pix   = w_new;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pix  <= n_out_pix;
        r_skid_pix <= n_skid_pix;
    end

    assign o_in_ready      = w_en;
    assign o_out_valid     = r_out_valid;
    assign o_red_level     = r_out_pix.red;
    assign o_green_level   = r_out_pix.green;
    assign o_blue_level    = r_out_pix.blue;
    assign o_input_invalid = r_out_pix.invalid;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // skid holds a beat only behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full with output empty");

    // skid fills only when the output was stalled
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid filled without a stall");

    // invalid beats carry all-zero levels
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_input_invalid) |->
            (o_red_level == '0 && o_green_level == '0 && o_blue_level == '0))
        else $error("invalid beat with nonzero level");

endmodule

// File: test/hsl_rgb_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// hsl_rgb_monitor
// Watches both channels of the HSL to RGB converter, works out the expected
// levels of every input beat and compares them with the output beats in order.
// ============================================================================
module hsl_rgb_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [hslrgb_pkg::HUE_W-1:0] i_hue_degrees,
    input  logic [hslrgb_pkg::PCT_W-1:0] i_saturation_pct,
    input  logic [hslrgb_pkg::PCT_W-1:0] i_lightness_pct,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [hslrgb_pkg::LVL_W-1:0] i_red_level,
    input  logic [hslrgb_pkg::LVL_W-1:0] i_green_level,
    input  logic [hslrgb_pkg::LVL_W-1:0] i_blue_level,
    input  logic                         i_input_invalid,
    output int                           o_mismatch_count,
    output int                           o_pending_count
);

    localparam longint unsigned RGB_DENOM = 600000;
    localparam int              MAX_REPORTS = 10;

    typedef struct packed {
        logic [hslrgb_pkg::LVL_W-1:0] red;
        logic [hslrgb_pkg::LVL_W-1:0] green;
        logic [hslrgb_pkg::LVL_W-1:0] blue;
        logic                         invalid;
    } t_rgb_pixel;

    // 60-degree hue sectors; hue 360 folds into the last one
    typedef enum logic [2:0] {
        HUE_RED_YELLOW,
        HUE_YELLOW_GREEN,
        HUE_GREEN_CYAN,
        HUE_CYAN_BLUE,
        HUE_BLUE_MAGENTA,
        HUE_MAGENTA_RED
    } t_hue_sector;

    t_rgb_pixel rgb_due[$];
    int         mismatches = 0;

    // numerator over 600000 -> 8-bit level, rounded half away from zero
    function automatic logic [hslrgb_pkg::LVL_W-1:0] to_level(input longint unsigned num);
        longint unsigned q;
        q = (510 * num + RGB_DENOM) / (2 * RGB_DENOM);
        return (q > hslrgb_pkg::LVL_MAX) ? hslrgb_pkg::LVL_MAX : q[hslrgb_pkg::LVL_W-1:0];
    endfunction

    function automatic t_rgb_pixel hsl_to_rgb_levels(
        input logic [hslrgb_pkg::HUE_W-1:0] hue,
        input logic [hslrgb_pkg::PCT_W-1:0] sat,
        input logic [hslrgb_pkg::PCT_W-1:0] lit);
        longint unsigned hv, sv, lv, span, chroma, hmod, ramp;
        longint unsigned c_num, x_num, m_num, r_num, g_num, b_num;
        t_hue_sector     sector;
        t_rgb_pixel      px;
        px = '0;
        if (hue > hslrgb_pkg::HUE_LIMIT || sat > hslrgb_pkg::PCT_MAX
                || lit > hslrgb_pkg::PCT_MAX) begin
            px.invalid = 1'b1;
            return px;
        end
        hv     = hue;
        sv     = sat;
        lv     = lit;
        span   = (2 * lv >= 100) ? (200 - 2 * lv) : (2 * lv);
        chroma = span * sv;
        hmod   = hv % 120;
        ramp   = 60 - ((hmod >= 60) ? (hmod - 60) : (60 - hmod));
        c_num  = 60 * chroma;
        x_num  = chroma * ramp;
        m_num  = 30 * (200 * lv - chroma);
        sector = (hv >= 300) ? HUE_MAGENTA_RED : t_hue_sector'(hv / 60);
        case (sector)
            HUE_RED_YELLOW: begin
                r_num = c_num; g_num = x_num; b_num = 0;
            end
            HUE_YELLOW_GREEN: begin
                r_num = x_num; g_num = c_num; b_num = 0;
            end
            HUE_GREEN_CYAN: begin
                r_num = 0; g_num = c_num; b_num = x_num;
            end
            HUE_CYAN_BLUE: begin
                r_num = 0; g_num = x_num; b_num = c_num;
            end
            HUE_BLUE_MAGENTA: begin
                r_num = x_num; g_num = 0; b_num = c_num;
            end
            default: begin
                r_num = c_num; g_num = 0; b_num = x_num;
            end
        endcase
        px.red   = to_level(r_num + m_num);
        px.green = to_level(g_num + m_num);
        px.blue  = to_level(b_num + m_num);
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_rgb_pixel got, want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                rgb_due.push_back(hsl_to_rgb_levels(i_hue_degrees, i_saturation_pct,
                                                    i_lightness_pct));
            if (i_out_valid && i_out_ready) begin
                got = '{i_red_level, i_green_level, i_blue_level, i_input_invalid};
                if (rgb_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected beat r=%0d g=%0d b=%0d inv=%0b",
                                 $realtime, got.red, got.green, got.blue, got.invalid);
                end else begin
                    want = rgb_due.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.invalid !== want.invalid) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     $realtime, want.red, want.green, want.blue,
                                     want.invalid, got.red, got.green, got.blue,
                                     got.invalid);
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= rgb_due.size();
    end

endmodule

// File: test/hsl_to_rgb_converter_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// hsl_to_rgb_converter_top_tb
// Drives HSL pixels into the converter with random gaps and output stalls;
// a monitor beside the block predicts each pixel's levels and checks them.
// ============================================================================
module hsl_to_rgb_converter_top_tb;

    localparam int RANDOM_PIXELS = 750;
    localparam int CHUNK         = 50;   // pacing mode changes per chunk
    localparam int DRAIN_CYCLES  = 24;   // well above the pipeline latency

    typedef logic [hslrgb_pkg::HUE_W-1:0] t_hue;
    typedef logic [hslrgb_pkg::PCT_W-1:0] t_pct;
    typedef logic [hslrgb_pkg::LVL_W-1:0] t_lvl;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_hue i_hue_degrees;
    t_pct i_saturation_pct;
    t_pct i_lightness_pct;
    logic o_out_valid;
    logic i_out_ready;
    t_lvl o_red_level;
    t_lvl o_green_level;
    t_lvl o_blue_level;
    logic o_input_invalid;

    int mismatch_count;
    int pending_count;

    // when set, neither side idles: back-to-back beats at full rate
    bit steady;

    hsl_to_rgb_converter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_hue_degrees    (i_hue_degrees),
        .i_saturation_pct (i_saturation_pct),
        .i_lightness_pct  (i_lightness_pct),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_red_level      (o_red_level),
        .o_green_level    (o_green_level),
        .o_blue_level     (o_blue_level),
        .o_input_invalid  (o_input_invalid)
    );

    hsl_rgb_monitor u_rgb_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_hue_degrees    (i_hue_degrees),
        .i_saturation_pct (i_saturation_pct),
        .i_lightness_pct  (i_lightness_pct),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_red_level      (o_red_level),
        .i_green_level    (o_green_level),
        .i_blue_level     (o_blue_level),
        .i_input_invalid  (o_input_invalid),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Hard stop, far beyond the slowest legal run of roughly 800 beats with
    // the largest idle gaps and output stalls.
    initial begin
        #2_000_000;
        $display("hsl_to_rgb_converter_top_tb failed");
        $finish;
    end

    // Send one beat after a random idle gap. Called right after a rising
    // edge; returns right after the edge where the beat was taken. With a
    // zero gap valid just stays high, so it only ever gets one NBA per step.
    task automatic push_pixel(input t_hue hue, input t_pct sat, input t_pct lit);
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_hue_degrees    <= hue;
        i_saturation_pct <= sat;
        i_lightness_pct  <= lit;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Random pixel: mostly in range (with extra weight on sector edges and
    // saturation/lightness extremes), the rest raw or out of range on a field.
    task automatic push_random_pixel();
        int   kind;
        t_hue hue;
        t_pct sat, lit;
        kind = int'($urandom_range(0, 99));
        hue  = t_hue'($urandom_range(0, hslrgb_pkg::HUE_LIMIT));
        sat  = t_pct'($urandom_range(0, hslrgb_pkg::PCT_MAX));
        lit  = t_pct'($urandom_range(0, hslrgb_pkg::PCT_MAX));
        if (kind < 12) begin
            // sector boundary, incl. 360
            hue = t_hue'(60 * $urandom_range(0, 6));
        end else if (kind < 20) begin
            sat = ($urandom_range(0, 1) != 0) ? hslrgb_pkg::PCT_MAX : '0;
            lit = ($urandom_range(0, 1) != 0) ? hslrgb_pkg::PCT_MAX
                                              : t_pct'($urandom_range(0, hslrgb_pkg::PCT_MAX));
        end else if (kind < 24) begin
            hue = t_hue'($urandom_range(hslrgb_pkg::HUE_LIMIT + 1, 511));
        end else if (kind < 28) begin
            sat = t_pct'($urandom_range(hslrgb_pkg::PCT_MAX + 1, 127));
        end else if (kind < 32) begin
            lit = t_pct'($urandom_range(hslrgb_pkg::PCT_MAX + 1, 127));
        end else if (kind < 36) begin
            // raw, full field widths
            hue = t_hue'($urandom_range(0, 511));
            sat = t_pct'($urandom_range(0, 127));
            lit = t_pct'($urandom_range(0, 127));
        end
        push_pixel(hue, sat, lit);
    endtask

    // Receiver: per beat, holds ready low for a random stall (none in steady
    // mode), then waits with ready high until a beat is taken.
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : int'($urandom_range(0, 9));
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_hue_degrees    <= '0;
        i_saturation_pct <= '0;
        i_lightness_pct  <= '0;
        steady           = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: black, white, pure colors, every sector edge (hue 360
        // must match hue 0), mid-ramp hues, tiny values, each field out of
        // range at its first and last illegal code.
        push_pixel(9'd0,   7'd0,   7'd0);
        push_pixel(9'd0,   7'd100, 7'd100);
        push_pixel(9'd0,   7'd100, 7'd0);
        push_pixel(9'd0,   7'd100, 7'd50);
        push_pixel(9'd60,  7'd100, 7'd50);
        push_pixel(9'd120, 7'd100, 7'd50);
        push_pixel(9'd180, 7'd100, 7'd50);
        push_pixel(9'd240, 7'd100, 7'd50);
        push_pixel(9'd300, 7'd100, 7'd50);
        push_pixel(9'd360, 7'd100, 7'd50);
        push_pixel(9'd30,  7'd100, 7'd50);
        push_pixel(9'd90,  7'd57,  7'd33);
        push_pixel(9'd359, 7'd100, 7'd50);
        push_pixel(9'd1,   7'd1,   7'd1);
        push_pixel(9'd210, 7'd73,  7'd99);
        push_pixel(9'd150, 7'd100, 7'd1);
        push_pixel(9'd361, 7'd50,  7'd50);
        push_pixel(9'd511, 7'd50,  7'd50);
        push_pixel(9'd0,   7'd101, 7'd50);
        push_pixel(9'd0,   7'd127, 7'd50);
        push_pixel(9'd0,   7'd50,  7'd101);
        push_pixel(9'd0,   7'd50,  7'd127);
        push_pixel(9'd511, 7'd127, 7'd127);

        // Random: every fourth chunk runs at full rate on both sides
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % CHUNK == 0)
                steady = ((n / CHUNK) % 4 == 3);
            push_random_pixel();
        end
        i_in_valid <= 1'b0;
        steady     = 1'b0;

        // drain, then a few extra cycles to catch anything spurious
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("hsl_to_rgb_converter_top_tb passed");
        end else begin
            $display("hsl_to_rgb_converter_top_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/hslrgb_pkg.sv
sv/hslrgb_chan_scale.sv
sv/hsl_to_rgb_converter_top.sv
test/hsl_rgb_monitor.sv
test/hsl_to_rgb_converter_top_tb.sv
